FILE: sv/tmf_pkg.sv
// Shared types and constants for the temporal median filter.
// No dependencies; imported by tmf_rank_unit, tmf_ring_mem and temporal_median_filter.
package tmf_pkg;

  localparam int SAMPLE_W   = 16;  // Q1.15 feature value
  localparam int CFG_W      = 3;   // half_window register width
  localparam int BIN_IDX_W  = 4;   // bin_index result field
  localparam int FBACK_W    = 3;   // frames_back result field
  localparam int OUT_DATA_W = 24;  // median, bin, frames_back, padded to bytes

  localparam logic [CFG_W-1:0] HALF_WINDOW_RESET = 3'd2;

  // Commands from the sequencer to the shared rank unit
  typedef struct packed {
    logic clear;  // zero both rank counters
    logic load;   // take the memory read data as the new candidate
    logic cmp;    // compare read data against the candidate and count
  } rank_ctrl_t;

endpackage

FILE: sv/tmf_ring_mem.sv
// Frame ring storage: one write port, one read port with registered read data.
// Depends on tmf_pkg for the sample width.
module tmf_ring_mem #(
  parameter int DEPTH  = 180,
  parameter int ADDR_W = 8
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ADDR_W-1:0]             waddr_i,
  input  logic [tmf_pkg::SAMPLE_W-1:0]  wdata_i,
  input  logic [ADDR_W-1:0]             raddr_i,
  output logic [tmf_pkg::SAMPLE_W-1:0]  rdata_o
);
  import tmf_pkg::*;

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tmf_rank_unit.sv
// Shared compare unit: holds a candidate and counts window values below / not above it.
// Depends on tmf_pkg for rank_ctrl_t and the sample width.
module tmf_rank_unit #(
  parameter int CNT_W = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmf_pkg::rank_ctrl_t           ctrl_i,
  input  logic [tmf_pkg::SAMPLE_W-1:0]  rdata_i,
  output logic [tmf_pkg::SAMPLE_W-1:0]  cand_o,
  output logic [CNT_W-1:0]              lt_sum_o,
  output logic [CNT_W-1:0]              le_sum_o
);
  import tmf_pkg::*;

  logic [SAMPLE_W-1:0] cand_q;
  logic [CNT_W-1:0]    lt_q;
  logic [CNT_W-1:0]    le_q;
  logic                is_lt;
  logic                is_eq;

  assign is_lt = $signed(rdata_i) < $signed(cand_q);
  assign is_eq = rdata_i == cand_q;

  // totals including the compare of this cycle
  assign lt_sum_o = lt_q + CNT_W'(ctrl_i.cmp && is_lt);
  assign le_sum_o = le_q + CNT_W'(ctrl_i.cmp && (is_lt || is_eq));
  assign cand_o   = cand_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cand_q <= rdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= '0;
      le_q <= '0;
    end else if (ctrl_i.clear) begin
      lt_q <= '0;
      le_q <= '0;
    end else if (ctrl_i.cmp) begin
      lt_q <= lt_sum_o;
      le_q <= le_sum_o;
    end
  end

endmodule

FILE: sv/temporal_median_filter.sv
// Streaming per-bin temporal median filter with edge replication (top level).
// Depends on tmf_pkg, tmf_ring_mem and tmf_rank_unit.
//
// Input stream: s_axis_tdata carries one feature value, frame-major, NUM_BINS per
// frame; s_axis_tlast flags values of the song's last frame. Each item is written
// into a frame ring, then zero, one or up to half_window+1 medians are produced.
// Output stream: m_axis_tdata carries median, bin and frames_back; m_axis_tlast marks
// the last result of an input item, m_axis_tuser the final result of the song.
// Configuration: cfg_valid_i/cfg_data_i write half_window (values above
// MAX_HALF_WINDOW act as MAX_HALF_WINDOW); write only while the block is idle.
// Operation: the block takes one item at a time. Each median is found by rank counting
// on one shared comparator fed by the single ring read port: each candidate is read,
// loaded and compared against the N window values (N = 2*half_window+1), at most N
// candidates are tried, and the median found is then loaded into the output register.
// Reset clears counters, the half_window register (to 2) and the output valid.
// When the receiver stalls, the finished result holds in the output register; the
// next input item is still accepted, and its first result waits for the register.
module temporal_median_filter #(
  parameter int MAX_HALF_WINDOW = 7,
  parameter int NUM_BINS        = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tmf_pkg::CFG_W-1:0]       cfg_data_i,    // half_window
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tmf_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // [15:0] sample_value
  input  logic                            s_axis_tlast,  // final_frame
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tmf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [15:0] median_value,
                                                         // [19:16] bin_index,
                                                         // [22:20] frames_back, [23] 0
  output logic                            m_axis_tlast,  // run_end
  output logic                            m_axis_tuser   // song_end
);
  import tmf_pkg::*;

  localparam int RING   = 2 * MAX_HALF_WINDOW + 1;
  localparam int DEPTH  = RING * NUM_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(RING);
  localparam int FR_W   = $clog2(RING + 1);
  localparam int HW_W   = $clog2(MAX_HALF_WINDOW + 1);
  localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int D_W    = FR_W + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CAND_RD = 3'd1;
  localparam logic [2:0] S_CAND_LD = 3'd2;
  localparam logic [2:0] S_CMP     = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]        state_q;
  logic [CFG_W-1:0]  hw_q;
  logic [BIN_W-1:0]  bin_q;
  logic [FR_W-1:0]   fr_q;
  logic [SLOT_W-1:0] slot_q;

  // per-item working registers
  logic [HW_W-1:0]   h_q;
  logic [FR_W-1:0]   n_q;
  logic [FR_W-1:0]   avail_q;
  logic [SLOT_W-1:0] base_q;
  logic [BIN_W-1:0]  b_q;
  logic [HW_W-1:0]   c_q;
  logic [HW_W-1:0]   c_end_q;
  logic              song_done_q;
  logic [FR_W-1:0]   k_q;
  logic [FR_W-1:0]   j_q;

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  m_last_q;
  logic                  m_user_q;

  logic              accept;
  logic              last_bin;
  logic [HW_W-1:0]   h_cl;
  logic [FR_W-1:0]   avail_new;
  logic [FR_W-1:0]   rd_pos;
  logic [D_W-1:0]    d_raw;
  logic [FR_W-1:0]   d_cl;
  logic [SLOT_W:0]   slot_diff;
  logic [SLOT_W-1:0] rd_slot;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [SAMPLE_W-1:0] rdata;
  logic [SAMPLE_W-1:0] cand;
  logic [FR_W-1:0]   lt_sum;
  logic [FR_W-1:0]   le_sum;
  logic              cmp_last;
  logic              found;
  logic              out_load;
  logic              run_end;
  rank_ctrl_t        rank_ctrl;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last_bin      = (bin_q == BIN_W'(NUM_BINS - 1));

  assign h_cl      = (int'(hw_q) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW) : HW_W'(hw_q);
  assign avail_new = (fr_q < FR_W'(RING - 1)) ? fr_q : FR_W'(RING - 1);

  always_comb begin
    unique case (state_q)
      S_CAND_RD: rd_pos = k_q;
      S_CMP:     rd_pos = j_q + FR_W'(1);
      default:   rd_pos = '0;
    endcase
  end

  // frames back from the newest frame for window position rd_pos, clamped to the song
  always_comb begin
    d_raw = D_W'(c_q) + D_W'(h_q) - D_W'(rd_pos);
    if (d_raw[D_W-1]) begin
      d_cl = '0;
    end else if (d_raw[FR_W-1:0] > avail_q) begin
      d_cl = avail_q;
    end else begin
      d_cl = d_raw[FR_W-1:0];
    end
    slot_diff = {1'b0, base_q} - (SLOT_W + 1)'(d_cl);
    if (slot_diff[SLOT_W]) begin
      rd_slot = SLOT_W'(slot_diff + (SLOT_W + 1)'(RING));
    end else begin
      rd_slot = slot_diff[SLOT_W-1:0];
    end
  end

  assign raddr = ADDR_W'(rd_slot) * ADDR_W'(NUM_BINS) + ADDR_W'(b_q);
  assign waddr = ADDR_W'(slot_q) * ADDR_W'(NUM_BINS) + ADDR_W'(bin_q);

  tmf_ring_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rank_ctrl.clear = (state_q == S_CAND_LD);
  assign rank_ctrl.load  = (state_q == S_CAND_LD);
  assign rank_ctrl.cmp   = (state_q == S_CMP);

  tmf_rank_unit #(
    .CNT_W (FR_W)
  ) u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (rank_ctrl),
    .rdata_i  (rdata),
    .cand_o   (cand),
    .lt_sum_o (lt_sum),
    .le_sum_o (le_sum)
  );

  assign cmp_last = (state_q == S_CMP) && (j_q == n_q - FR_W'(1));
  // candidate is the median when fewer than h+1 values lie below it and at least h+1
  // lie at or below it
  assign found    = (lt_sum <= FR_W'(h_q)) && (le_sum > FR_W'(h_q));
  assign out_load = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready);
  assign run_end  = (c_q == c_end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HALF_WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hw_q <= cfg_data_i;
    end
  end

  // song position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q  <= '0;
      fr_q   <= '0;
      slot_q <= '0;
    end else if (accept) begin
      if (last_bin) begin
        bin_q <= '0;
        if (s_axis_tlast) begin
          fr_q   <= '0;
          slot_q <= '0;
        end else begin
          slot_q <= (slot_q == SLOT_W'(RING - 1)) ? '0 : slot_q + SLOT_W'(1);
          if (fr_q < FR_W'(RING)) begin
            fr_q <= fr_q + FR_W'(1);
          end
        end
      end else begin
        bin_q <= bin_q + BIN_W'(1);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      h_q         <= '0;
      n_q         <= '0;
      avail_q     <= '0;
      base_q      <= '0;
      b_q         <= '0;
      c_q         <= '0;
      c_end_q     <= '0;
      song_done_q <= 1'b0;
      k_q         <= '0;
      j_q         <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            h_q         <= h_cl;
            n_q         <= FR_W'({h_cl, 1'b1});
            avail_q     <= avail_new;
            base_q      <= slot_q;
            b_q         <= bin_q;
            song_done_q <= s_axis_tlast && last_bin;
            k_q         <= '0;
            if (s_axis_tlast) begin
              // flush: from the oldest pending centre down to the newest frame
              c_q     <= (fr_q < FR_W'(h_cl)) ? HW_W'(fr_q) : h_cl;
              c_end_q <= '0;
              state_q <= S_CAND_RD;
            end else if (fr_q >= FR_W'(h_cl)) begin
              c_q     <= h_cl;
              c_end_q <= h_cl;
              state_q <= S_CAND_RD;
            end
          end
        end
        S_CAND_RD: begin
          state_q <= S_CAND_LD;
        end
        S_CAND_LD: begin
          j_q     <= '0;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (cmp_last) begin
            if (found) begin
              state_q <= S_EMIT;
            end else begin
              k_q     <= k_q + FR_W'(1);
              state_q <= S_CAND_RD;
            end
          end else begin
            j_q <= j_q + FR_W'(1);
          end
        end
        S_EMIT: begin
          if (out_load) begin
            k_q <= '0;
            if (run_end) begin
              state_q <= S_IDLE;
            end else begin
              c_q     <= c_q - HW_W'(1);
              state_q <= S_CAND_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {1'b0, FBACK_W'(c_q), BIN_IDX_W'(b_q), cand};
      m_last_q <= run_end;
      m_user_q <= run_end && song_done_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

  // the compare scan never runs past the window
  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (j_q < n_q))
    else $error("compare index beyond window");

  // some candidate is always the median before the window runs out
  a_cand_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CAND_RD) |-> (k_q < n_q))
    else $error("no median found in window");

  // the flush counts down and never passes its end frame
  a_centre_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (c_q >= c_end_q))
    else $error("centre frame below end of run");

  // a result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready))
    else $error("output register overwritten");

  // input is refused while an item is in work
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready)
    else $error("input accepted while busy");

endmodule
